// ===== rtl/dr96_pkg.sv =====
// Package for the 96-bit decimal integer rounding block.
// Holds the command codes, sequencer states and divide-by-ten constants.
// No dependencies.
package dr96_pkg;

  localparam int LIMB_W  = 32;
  localparam int NLIMBS  = 3;
  localparam int REM_W   = 4;
  localparam int CUR_W   = REM_W + LIMB_W;
  localparam int SCALE_W = 5;

  // ceil(2^38 / 10): floor(cur * recip / 2^38) is exact for cur < 10 * 2^32
  localparam int RECIP_SHIFT = 38;
  localparam int RECIP_W     = 35;
  localparam logic [RECIP_W-1:0] DIV10_RECIP = 35'd27487790695;

  localparam logic [REM_W-1:0] ROUND_HALF = 4'd5;

  typedef enum logic [1:0] {
    CMD_TRUNC = 2'd0,
    CMD_FLOOR = 2'd1,
    CMD_ROUND = 2'd2,
    CMD_NEG   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_INC,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/dr96_div_step.sv =====
// One limb step of a long division by ten: {remainder, limb} / 10.
// Quotient by reciprocal multiplication, remainder by shift-add back-multiply.
// Depends on dr96_pkg.
module dr96_div_step (
  input  logic [dr96_pkg::REM_W-1:0]  rem_in,
  input  logic [dr96_pkg::LIMB_W-1:0] limb_in,
  output logic [dr96_pkg::LIMB_W-1:0] quot,
  output logic [dr96_pkg::REM_W-1:0]  rem_out
);
  import dr96_pkg::*;

  localparam int PROD_W = CUR_W + RECIP_W;

  logic [CUR_W-1:0]  cur;
  logic [PROD_W-1:0] prod;
  logic [CUR_W-1:0]  back;
  logic [CUR_W-1:0]  diff;

  assign cur  = {rem_in, limb_in};
  assign prod = PROD_W'(cur) * PROD_W'(DIV10_RECIP);
  assign quot = prod[RECIP_SHIFT +: LIMB_W];

  // quot * 10 = quot * 8 + quot * 2
  assign back    = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
  assign diff    = cur - back;
  assign rem_out = diff[REM_W-1:0];

endmodule

// ===== rtl/decimal96_integer_rounding.sv =====
// Top level of the 96-bit decimal integer rounding block.
// Sequencer and mantissa registers around one shared divide-by-ten limb step.
// Depends on dr96_pkg and dr96_div_step.
//
// Usage:
//   Drive in_* and raise start; the request is taken at a clock edge where
//   start is high and busy is low. busy stays high until the result is out.
//   The result appears on out_* for exactly one cycle with out_valid high.
//   Truncate, floor and round divide the 96-bit mantissa by ten once per
//   scale digit; each digit walks the three 32-bit limbs, high to low,
//   through the single divide step. Negate, scale zero and a scale above
//   MAX_SCALE pass straight to the result state. A new request may be
//   accepted the cycle after the strobe; none is taken while busy is high.
//   The receiver cannot stall: out_valid is a single-cycle pulse.
//   Reset (synchronous, rst_n low) returns the sequencer to idle and drops
//   any request in progress; no result is given for it.
module decimal96_integer_rounding #(
  parameter int MAX_SCALE = 28
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_command,
  input  logic [63:0]                     in_mant_low,
  input  logic [31:0]                     in_mant_high,
  input  logic                            in_negative,
  input  logic [dr96_pkg::SCALE_W-1:0]    in_scale_in,
  output logic                            out_valid,
  output logic [63:0]                     out_res_low,
  output logic [31:0]                     out_res_high,
  output logic                            out_res_negative,
  output logic [dr96_pkg::SCALE_W-1:0]    out_res_scale,
  output logic                            out_bad_scale
);
  import dr96_pkg::*;

  localparam logic [SCALE_W-1:0] MAX_SCALE_V = SCALE_W'(MAX_SCALE);
  localparam int MANT_W = NLIMBS * LIMB_W;

  state_t                         state_r, state_nxt;
  logic [NLIMBS-1:0][LIMB_W-1:0]  mant_r, mant_nxt;
  logic [1:0]                     limb_idx_r, limb_idx_nxt;
  logic [REM_W-1:0]               rem_r, rem_nxt;
  logic [REM_W-1:0]               first_r, first_nxt;
  logic                           any_r, any_nxt;
  logic [SCALE_W-1:0]             digits_r, digits_nxt;
  logic [SCALE_W-1:0]             scale_r, scale_nxt;
  cmd_t                           cmd_r, cmd_nxt;
  logic                           neg_r, neg_nxt;
  logic                           bad_r, bad_nxt;
  logic                           keep_scale_r, keep_scale_nxt;

  logic [LIMB_W-1:0]              step_quot;
  logic [REM_W-1:0]               step_rem;
  logic                           in_bad;
  logic                           bump;

  dr96_div_step u_div_step (
    .rem_in  (rem_r),
    .limb_in (mant_r[limb_idx_r]),
    .quot    (step_quot),
    .rem_out (step_rem)
  );

  assign in_bad = in_scale_in > MAX_SCALE_V;
  assign bump   = ((cmd_r == CMD_FLOOR) && neg_r && any_r) ||
                  ((cmd_r == CMD_ROUND) && (first_r >= ROUND_HALF));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mant_r       <= mant_nxt;
    limb_idx_r   <= limb_idx_nxt;
    rem_r        <= rem_nxt;
    first_r      <= first_nxt;
    any_r        <= any_nxt;
    digits_r     <= digits_nxt;
    scale_r      <= scale_nxt;
    cmd_r        <= cmd_nxt;
    neg_r        <= neg_nxt;
    bad_r        <= bad_nxt;
    keep_scale_r <= keep_scale_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    mant_nxt       = mant_r;
    limb_idx_nxt   = limb_idx_r;
    rem_nxt        = rem_r;
    first_nxt      = first_r;
    any_nxt        = any_r;
    digits_nxt     = digits_r;
    scale_nxt      = scale_r;
    cmd_nxt        = cmd_r;
    neg_nxt        = neg_r;
    bad_nxt        = bad_r;
    keep_scale_nxt = keep_scale_r;
    busy           = 1'b1;
    out_valid      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          mant_nxt       = {in_mant_high, in_mant_low};
          limb_idx_nxt   = 2'(NLIMBS - 1);
          rem_nxt        = '0;
          first_nxt      = '0;
          any_nxt        = 1'b0;
          digits_nxt     = in_scale_in;
          scale_nxt      = in_scale_in;
          cmd_nxt        = cmd_t'(in_command);
          bad_nxt        = in_bad;
          keep_scale_nxt = in_bad || (cmd_t'(in_command) == CMD_NEG);
          neg_nxt        = in_negative ^ (!in_bad && (cmd_t'(in_command) == CMD_NEG));
          // pass-through cases skip the divider entirely
          if (in_bad || (cmd_t'(in_command) == CMD_NEG) || (in_scale_in == '0)) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        mant_nxt[limb_idx_r] = step_quot;
        if (limb_idx_r == '0) begin
          // digit finished: record it, restart from the high limb
          first_nxt    = step_rem;
          any_nxt      = any_r || (step_rem != '0);
          rem_nxt      = '0;
          limb_idx_nxt = 2'(NLIMBS - 1);
          digits_nxt   = digits_r - 1'b1;
          if (digits_r == SCALE_W'(1)) begin
            state_nxt = ST_INC;
          end
        end else begin
          rem_nxt      = step_rem;
          limb_idx_nxt = limb_idx_r - 1'b1;
        end
      end
      ST_INC: begin
        if (bump) begin
          mant_nxt = mant_r + MANT_W'(1);
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_res_low      = {mant_r[1], mant_r[0]};
  assign out_res_high     = mant_r[2];
  assign out_res_negative = neg_r;
  assign out_res_scale    = keep_scale_r ? scale_r : '0;
  assign out_bad_scale    = bad_r;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_div_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (digits_r != '0))
    else $error("divider running with no digits left");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r <= 4'd9))
    else $error("running remainder out of decimal range");

  a_limb_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (limb_idx_r <= 2'(NLIMBS - 1)))
    else $error("limb index past the top limb");
`endif

endmodule

// ===== dv/tb_top.sv =====
// Testbench for decimal96_integer_rounding: directed and random requests checked
// against a predictor of truncate, floor, round and negate on 96-bit decimals.
// Depends on dr96_pkg and the decimal96_integer_rounding RTL.
module tb_top;
  import dr96_pkg::*;

  localparam int MAX_SCALE = 28;
  localparam int CLK_PERIOD = 12;
  localparam int RANDOM_ITEMS = 500;
  localparam logic [95:0] MANT_MAX = {96{1'b1}};

  typedef struct packed {
    logic [63:0] lo;
    logic [31:0] hi;
    logic        neg;
    logic [4:0]  scale;
    logic        bad;
  } rounding_result_t;

  class round_scoreboard;
    rounding_result_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("tb_top: mismatch: %s", msg);
    endtask

    // Integer part of the decimal under the given command, halves away from zero.
    function rounding_result_t rounded_value(cmd_t cmd, logic [95:0] mant, logic neg,
                                             logic [4:0] scale);
      rounding_result_t r;
      logic [95:0] m;
      logic [95:0] digit;
      logic dropped_nonzero;
      m = mant;
      digit = '0;
      dropped_nonzero = 1'b0;
      r.lo = mant[63:0];
      r.hi = mant[95:64];
      r.neg = neg;
      r.scale = scale;
      r.bad = 1'b0;
      if (scale > MAX_SCALE) begin
        r.bad = 1'b1;
        return r;
      end
      if (cmd == CMD_NEG) begin
        r.neg = ~neg;
        return r;
      end
      for (int i = 0; i < scale; i++) begin
        digit = m % 96'd10;
        m = m / 96'd10;
        if (digit != 0) dropped_nonzero = 1'b1;
      end
      if (cmd == CMD_FLOOR && neg && dropped_nonzero) m = m + 96'd1;
      if (cmd == CMD_ROUND && scale != 0 && digit >= 5) m = m + 96'd1;
      r.lo = m[63:0];
      r.hi = m[95:64];
      r.scale = '0;
      return r;
    endfunction

    function void note_request(cmd_t cmd, logic [95:0] mant, logic neg, logic [4:0] scale);
      pending.push_back(rounded_value(cmd, mant, neg, scale));
    endfunction

    task check_result(logic [63:0] lo, logic [31:0] hi, logic neg,
                      logic [4:0] scale, logic bad);
      rounding_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("result with nothing pending: %h_%h", hi, lo));
        return;
      end
      want = pending.pop_front();
      if (lo !== want.lo) report($sformatf("res_low %h, want %h", lo, want.lo));
      if (hi !== want.hi) report($sformatf("res_high %h, want %h", hi, want.hi));
      if (neg !== want.neg) report($sformatf("res_negative %b, want %b", neg, want.neg));
      if (scale !== want.scale) report($sformatf("res_scale %0d, want %0d", scale, want.scale));
      if (bad !== want.bad) report($sformatf("bad_scale %b, want %b", bad, want.bad));
    endtask

    task flush_leftover();
      if (pending.size() != 0)
        report($sformatf("%0d results never arrived", pending.size()));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_command;
  logic [63:0] in_mant_low;
  logic [31:0] in_mant_high;
  logic        in_negative;
  logic [4:0]  in_scale_in;
  logic        out_valid;
  logic [63:0] out_res_low;
  logic [31:0] out_res_high;
  logic        out_res_negative;
  logic [4:0]  out_res_scale;
  logic        out_bad_scale;

  round_scoreboard sb;
  int no_idle_left;

  decimal96_integer_rounding #(.MAX_SCALE(MAX_SCALE)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_command(in_command),
    .in_mant_low(in_mant_low),
    .in_mant_high(in_mant_high),
    .in_negative(in_negative),
    .in_scale_in(in_scale_in),
    .out_valid(out_valid),
    .out_res_low(out_res_low),
    .out_res_high(out_res_high),
    .out_res_negative(out_res_negative),
    .out_res_scale(out_res_scale),
    .out_bad_scale(out_bad_scale)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic logic [127:0] pow10(int n);
    logic [127:0] p;
    p = 128'd1;
    for (int i = 0; i < n; i++) p = p * 128'd10;
    return p;
  endfunction

  // Mix of raw bit patterns and values built around the digit that rounding looks at.
  function automatic logic [95:0] pick_mantissa(logic [4:0] scale);
    logic [127:0] p;
    logic [127:0] q;
    logic [127:0] m;
    logic [95:0] raw;
    int s;
    s = (scale > MAX_SCALE) ? 0 : scale;
    raw = {$urandom, $urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return raw;
      1: return {64'd0, raw[31:0]};
      2: return raw >> $urandom_range(0, 95);
      default: begin
        p = pow10(s);
        q = {32'd0, raw} / p;
        case ($urandom_range(0, 3))
          0: m = q * p;
          1: m = q * p + p / 2;
          2: m = (s == 0) ? q * p : q * p + p / 2 - 1;
          default: m = q * p + ({32'd0, $urandom, $urandom, $urandom} % p);
        endcase
        // pull back under 2^96 without touching the low digits
        if (m > {32'd0, MANT_MAX}) m = m - p;
        return m[95:0];
      end
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(cmd_t cmd, logic [95:0] mant, logic neg, logic [4:0] scale);
    int gap;
    if (no_idle_left > 0) begin
      gap = 0;
      no_idle_left--;
    end else begin
      if ($urandom_range(0, 15) == 0) no_idle_left = $urandom_range(10, 30);
      gap = $urandom_range(0, 4);
    end
    if (gap > 0) begin
      start <= 1'b0;
      in_command <= 2'($urandom_range(0, 3));
      in_mant_low <= {$urandom, $urandom};
      in_mant_high <= $urandom;
      in_negative <= 1'($urandom_range(0, 1));
      in_scale_in <= 5'($urandom_range(0, 31));
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_mant_low <= mant[63:0];
    in_mant_high <= mant[95:64];
    in_negative <= neg;
    in_scale_in <= scale;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(cmd, mant, neg, scale);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1)
      sb.check_result(out_res_low, out_res_high, out_res_negative, out_res_scale,
                      out_bad_scale);
  end

  initial begin
    cmd_t cmd;
    logic [4:0] scale;
    int waited;
    sb = new();
    no_idle_left = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_command = CMD_TRUNC;
    in_mant_low = '0;
    in_mant_high = '0;
    in_negative = 1'b0;
    in_scale_in = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_request(CMD_TRUNC, 96'd0, 1'b0, 5'd0);
    send_request(CMD_FLOOR, MANT_MAX, 1'b1, 5'd0);
    send_request(CMD_ROUND, MANT_MAX, 1'b0, 5'd28);
    send_request(CMD_TRUNC, MANT_MAX, 1'b1, 5'd28);
    send_request(CMD_FLOOR, MANT_MAX, 1'b1, 5'd28);
    send_request(CMD_ROUND, MANT_MAX, 1'b1, 5'd1);
    send_request(CMD_NEG, 96'd0, 1'b0, 5'd0);
    send_request(CMD_NEG, MANT_MAX, 1'b1, 5'd28);
    // scales past the limit pass through for every command
    send_request(CMD_TRUNC, MANT_MAX, 1'b0, 5'd29);
    send_request(CMD_FLOOR, 96'd123456789, 1'b1, 5'd30);
    send_request(CMD_ROUND, 96'h8000_0000_0000_0000_0000_0000, 1'b0, 5'd31);
    send_request(CMD_NEG, 96'd5, 1'b1, 5'd31);
    // floor of a negative, exact versus inexact, and of a positive
    send_request(CMD_FLOOR, 96'd1000, 1'b1, 5'd3);
    send_request(CMD_FLOOR, 96'd1001, 1'b1, 5'd3);
    send_request(CMD_FLOOR, 96'd1999, 1'b0, 5'd3);
    send_request(CMD_FLOOR, 96'd1, 1'b1, 5'd28);
    // halves round away from zero
    send_request(CMD_ROUND, 96'd15, 1'b0, 5'd1);
    send_request(CMD_ROUND, 96'd14, 1'b1, 5'd1);
    send_request(CMD_ROUND, 96'd25, 1'b1, 5'd1);
    send_request(CMD_ROUND, 96'd5000, 1'b0, 5'd4);
    send_request(CMD_ROUND, 96'd4999, 1'b0, 5'd4);
    // negative zero keeps its sign, plus a large truncate and a large round
    send_request(CMD_TRUNC, 96'd5, 1'b1, 5'd1);
    send_request(CMD_TRUNC, 96'(pow10(28)), 1'b0, 5'd28);
    send_request(CMD_ROUND, 96'h0000_0000_8000_0000_0000_0000, 1'b1, 5'd2);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      cmd = cmd_t'($urandom_range(0, 3));
      if ($urandom_range(0, 9) == 0) scale = 5'($urandom_range(29, 31));
      else scale = 5'($urandom_range(0, MAX_SCALE));
      send_request(cmd, pick_mantissa(scale), 1'($urandom_range(0, 1)), scale);
    end
    start <= 1'b0;

    waited = 0;
    while (sb.pending.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    sb.flush_leftover();
    if (sb.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * 1000000);
    $display("tb_top: done, errors");
    $finish;
  end
endmodule
